// ----- rtl/core/bloom_filter_insert_query_macros.svh -----
// ----------------------------------------------------------------------------
// Bloom filter insert/query engine: assertion macros
// Shared property checks, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_MACROS_SVH

// Check that is switched off while reset is held
`define BFIQ_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Check that must hold through reset as well
`define BFIQ_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- rtl/core/bfiq_pkg.sv -----
// ----------------------------------------------------------------------------
// Bloom filter insert/query engine: package
// Payload types, operation codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package bfiq_pkg;

  localparam int HASH_W   = 32;
  localparam int KIND_W   = 2;
  // modulo works on the hash without its three bit-select bits
  localparam int DIV_W    = HASH_W - 3;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int ROT_AMT  = 17;

  localparam int DEF_MAX_FILTER_BYTES = 1024;
  localparam int DEF_MAX_PROBES       = 30;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  localparam int FB_W       = 11;
  localparam int NP_W       = 8;
  localparam int FB_RESET   = 8;
  localparam int NP_RESET   = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROBES   = 4'd1;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HASH_W-1:0] hash_value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] done_kind;
    logic              may_match;
  } out_item_t;

  // request to the shared modulo unit
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } mod_req_t;

endpackage

// ----- rtl/core/bloom_filter_insert_query.sv -----
// Insert/query with k probes: each probe starts the bit-serial modulo unit
//   (29 steps), takes its remainder as the byte address, then reads the store
//   byte and, for an insert, writes it back with the probe bit set.
// Clear, reset, and the cases that skip probing: a clear zeroes all
//   MAX_FILTER_BYTES store bytes; an item that probes nothing goes to its result.
// Reset: synchronous, active low; afterwards a clearing pass over all store bytes
//   runs with in_ready low. Config writes are taken at any time but during reset.
// ----------------------------------------------------------------------------
// Bloom filter insert/query engine: top level
// Double-hashing probe sequencer around a shared modulo unit and a byte store.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query #(
  parameter int MAX_FILTER_BYTES = bfiq_pkg::DEF_MAX_FILTER_BYTES,
  parameter int MAX_PROBES       = bfiq_pkg::DEF_MAX_PROBES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bfiq_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bfiq_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW   = $clog2(MAX_FILTER_BYTES);
  localparam int NB_W = $clog2(MAX_FILTER_BYTES + 1);
  localparam int CW   = (NB_W > bfiq_pkg::FB_W) ? NB_W : bfiq_pkg::FB_W;
  localparam int PW   = $clog2(MAX_PROBES + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_DONE
  } state_t;

  state_t                          state_r;
  logic [AW-1:0]                   clr_addr_r;
  logic                            clr_report_r;
  logic [bfiq_pkg::KIND_W-1:0]     kind_r;
  logic [bfiq_pkg::HASH_W-1:0]     hv_r;
  logic [bfiq_pkg::HASH_W-1:0]     delta_r;
  logic [PW-1:0]                   probe_cnt_r;
  logic                            match_r;
  logic                            mod_start_r;
  logic [AW-1:0]                   addr_r;
  logic                            out_valid_r;
  bfiq_pkg::out_item_t             out_data_r;
  logic [bfiq_pkg::FB_W-1:0]       fb_r;
  logic [bfiq_pkg::NP_W-1:0]       np_r;

  logic [CW-1:0]                   fb_ext;
  logic [CW-1:0]                   act_bytes;
  logic [NB_W-1:0]                 nbytes;
  logic                            too_many;
  logic                            no_probes;
  logic                            probe_ok;
  logic                            mod_start_nxt;
  logic [PW-1:0]                   cnt_inc;
  logic                            last_probe;
  logic [7:0]                      bit_mask;
  logic                            bit_set;
  logic                            can_load;

  bfiq_pkg::mod_req_t              mod_req;
  logic                            mod_done;
  logic [NB_W-1:0]                 mod_rem;

  logic                            st_we;
  logic [AW-1:0]                   st_waddr;
  logic [7:0]                      st_wdata;
  logic                            st_re;
  logic [7:0]                      st_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= bfiq_pkg::FB_W'(bfiq_pkg::FB_RESET);
      np_r <= bfiq_pkg::NP_W'(bfiq_pkg::NP_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == bfiq_pkg::CFG_FILTER_BYTES) begin
        fb_r <= cfg_data[bfiq_pkg::FB_W-1:0];
      end else if (cfg_index == bfiq_pkg::CFG_NUM_PROBES) begin
        np_r <= cfg_data[bfiq_pkg::NP_W-1:0];
      end
    end
  end

  // active size, capped at the store depth
  assign fb_ext    = CW'(fb_r);
  assign act_bytes = (fb_ext > CW'(MAX_FILTER_BYTES)) ? CW'(MAX_FILTER_BYTES) : fb_ext;
  assign nbytes    = act_bytes[NB_W-1:0];
  assign too_many  = (np_r > bfiq_pkg::NP_W'(MAX_PROBES));
  assign no_probes = (np_r == '0);
  assign probe_ok  = (nbytes != '0) && !too_many && !no_probes;

  // probe bookkeeping
  assign cnt_inc    = probe_cnt_r + 1'b1;
  assign last_probe = (cnt_inc == np_r[PW-1:0]);
  assign bit_mask   = 8'(1) << hv_r[2:0];
  assign bit_set    = |(st_rdata & bit_mask);
  assign can_load   = !out_valid_r || out_ready;

  // kick the modulo unit on an accepted probing beat or a further probe
  assign mod_start_nxt = ((state_r == ST_IDLE) && in_valid && probe_ok &&
                          ((in_data.kind == bfiq_pkg::KIND_INSERT) ||
                           (in_data.kind == bfiq_pkg::KIND_QUERY))) ||
                         ((state_r == ST_READ) && !last_probe &&
                          !((kind_r == bfiq_pkg::KIND_QUERY) && !bit_set));

  // shared modulo: bit position = 8*((hv>>3) mod nbytes) + hv[2:0]
  assign mod_req.start    = mod_start_r;
  assign mod_req.dividend = hv_r[bfiq_pkg::HASH_W-1:3];

  bfiq_mod_unit #(
    .DIVISOR_W (NB_W)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mod_req),
    .divisor (nbytes),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // store access: sweep writes zero, insert writes back the read byte with the probe bit set
  assign st_re    = (state_r == ST_MOD) && mod_done;
  assign st_we    = (state_r == ST_CLEAR) ||
                    ((state_r == ST_READ) && (kind_r == bfiq_pkg::KIND_INSERT));
  assign st_waddr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign st_wdata = (state_r == ST_CLEAR) ? 8'h00 : (st_rdata | bit_mask);

  bfiq_store #(
    .DEPTH (MAX_FILTER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (mod_rem[AW-1:0]),
    .rdata (st_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      mod_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      mod_start_r <= mod_start_nxt;
      if ((state_r == ST_DONE) && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(MAX_FILTER_BYTES - 1)) begin
            state_r <= clr_report_r ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            kind_r      <= in_data.kind;
            hv_r        <= in_data.hash_value;
            delta_r     <= {in_data.hash_value[bfiq_pkg::ROT_AMT-1:0],
                            in_data.hash_value[bfiq_pkg::HASH_W-1:bfiq_pkg::ROT_AMT]};
            probe_cnt_r <= '0;
            unique case (in_data.kind)
              bfiq_pkg::KIND_CLEAR: begin
                match_r      <= 1'b0;
                clr_addr_r   <= '0;
                clr_report_r <= 1'b1;
                state_r      <= ST_CLEAR;
              end
              bfiq_pkg::KIND_INSERT: begin
                match_r <= 1'b0;
                if ((nbytes == '0) || too_many || no_probes) begin
                  state_r <= ST_DONE;
                end else begin
                  state_r <= ST_MOD;
                end
              end
              bfiq_pkg::KIND_QUERY: begin
                if (nbytes == '0) begin
                  match_r <= 1'b0;
                  state_r <= ST_DONE;
                end else if (too_many || no_probes) begin
                  match_r <= 1'b1;
                  state_r <= ST_DONE;
                end else begin
                  match_r <= 1'b1;
                  state_r <= ST_MOD;
                end
              end
              bfiq_pkg::KIND_RSVD: begin
                match_r <= 1'b0;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            addr_r  <= mod_rem[AW-1:0];
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          hv_r        <= hv_r + delta_r;
          probe_cnt_r <= cnt_inc;
          if ((kind_r == bfiq_pkg::KIND_QUERY) && !bit_set) begin
            match_r <= 1'b0;
            state_r <= ST_DONE;
          end else if (last_probe) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_MOD;
          end
        end
        ST_DONE: begin
          if (can_load) begin
            out_data_r.done_kind <= kind_r;
            out_data_r.may_match <= match_r;
            clr_report_r         <= 1'b0;
            state_r              <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "bloom_filter_insert_query_macros.svh"

  `BFIQ_ASSERT(a_match_query_only, clk, rst_n, (out_valid_r && (out_data_r.done_kind != bfiq_pkg::KIND_QUERY)) |-> !out_data_r.may_match, "match flagged on a non-query result")
  `BFIQ_ASSERT(a_probe_bound, clk, rst_n, (state_r == ST_READ) |-> (probe_cnt_r < np_r[PW-1:0]), "probe count ran past num_probes")
  `BFIQ_ASSERT(a_probe_kind, clk, rst_n, (state_r == ST_MOD) |-> (((kind_r == bfiq_pkg::KIND_INSERT) || (kind_r == bfiq_pkg::KIND_QUERY)) && (nbytes != '0)), "probing without insert or query on a non-empty filter")

endmodule

// ----- rtl/core/bfiq_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Bloom filter engine: iterative modulo unit
// Restoring remainder, one dividend bit per cycle, shared by all probes.
// ----------------------------------------------------------------------------
module bfiq_mod_unit #(
  parameter int DIVISOR_W = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfiq_pkg::mod_req_t    req,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  rem
);

  logic                            busy_r;
  logic                            done_r;
  logic [bfiq_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [bfiq_pkg::DIV_W-1:0]      shreg_r;
  logic [DIVISOR_W-1:0]            rem_r;

  logic [DIVISOR_W:0]              trial;
  logic [DIVISOR_W:0]              div_ext;
  logic [DIVISOR_W:0]              diff;
  logic [DIVISOR_W-1:0]            rem_nxt;

  // one compare-subtract step
  assign trial   = {rem_r, shreg_r[bfiq_pkg::DIV_W-1]};
  assign div_ext = {1'b0, divisor};
  assign diff    = trial - div_ext;
  assign rem_nxt = (trial >= div_ext) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= bfiq_pkg::DIV_CNT_W'(bfiq_pkg::DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == bfiq_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg_r <= req.dividend;
      rem_r   <= '0;
    end else if (busy_r) begin
      shreg_r <= {shreg_r[bfiq_pkg::DIV_W-2:0], 1'b0};
      rem_r   <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  `include "bloom_filter_insert_query_macros.svh"

  `BFIQ_ASSERT(a_start_idle, clk, rst_n, req.start |-> !busy_r, "modulo restarted while busy")
  `BFIQ_ASSERT(a_rem_range, clk, rst_n, done_r |-> (rem_r < divisor), "remainder not below divisor")

endmodule

// ----- rtl/core/bfiq_store.sv -----
// ----------------------------------------------------------------------------
// Bloom filter engine: bit store
// Byte-wide memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfiq_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Bloom filter insert/query engine: testbench
// Drives clear, insert, query and reserved beats through the valid/ready input channel,
// keeps a bit-accurate copy of the filter store and its two size registers,
// and checks every result beat in order against that copy.
// ----------------------------------------------------------------------------
module testbench;
  import bfiq_pkg::*;

  localparam int     CLK_HALF     = 6;
  localparam int     RESET_CYCLES = 8;
  localparam int     MAX_BYTES    = DEF_MAX_FILTER_BYTES;
  localparam int     MAX_K        = DEF_MAX_PROBES;
  // a clear is the slowest operation, a sweep over every store byte
  localparam int     TAIL_CYCLES  = MAX_BYTES + 100;
  localparam int     HOLD_CYCLES  = 600;
  localparam longint CYCLE_LIMIT  = 5_000_000;
  localparam int     SHOW_LIMIT   = 10;
  localparam int     POOL_DEPTH   = 64;
  localparam int     N_PHASES     = 12;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow of the block: store contents and size registers
  bit [7:0]      filter_mem [MAX_BYTES];
  bit [FB_W-1:0] cfg_fbytes  = FB_W'(FB_RESET);
  bit [NP_W-1:0] cfg_nprobes = NP_W'(NP_RESET);

  out_item_t     pending_results [$];
  bit [31:0]     key_pool [$];
  int unsigned   fail_count  = 0;
  int unsigned   burst_left  = 0;
  longint        cycle_count = 0;

  // receiver pacing
  int unsigned   hold_requests = 0;
  int unsigned   hold_served   = 0;
  int unsigned   hold_left     = 0;
  int unsigned   stall_mode    = 0;
  int unsigned   pattern_left  = 0;
  out_item_t     want;

  bloom_filter_insert_query u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Apply one beat to the shadow store and return the result it should give.
  // Probe positions follow double hashing: h, h+d, h+2d, ... mod bit count,
  // with d the hash rotated right by 17.
  function automatic out_item_t filter_apply(input in_item_t item);
    out_item_t   res;
    bit [31:0]   h;
    bit [31:0]   delta;
    bit [31:0]   pos;
    bit [31:0]   nbytes;
    bit [31:0]   nbits;
    bit          hit;
    int          j;
    res.done_kind = item.kind;
    res.may_match = 1'b0;
    nbytes = (cfg_fbytes > MAX_BYTES) ? MAX_BYTES : cfg_fbytes;
    nbits  = nbytes * 8;
    h      = item.hash_value;
    delta  = {h[16:0], h[31:17]};
    case (item.kind)
      KIND_CLEAR: begin
        // whole store, whatever the configured size
        foreach (filter_mem[i]) filter_mem[i] = 8'h00;
      end
      KIND_INSERT: begin
        if (nbytes != 0 && cfg_nprobes <= MAX_K) begin
          for (j = 0; j < cfg_nprobes; j++) begin
            pos = h % nbits;
            filter_mem[pos >> 3][pos[2:0]] = 1'b1;
            h += delta;
          end
        end
      end
      KIND_QUERY: begin
        if (nbytes == 0) begin
          hit = 1'b0;
        end else if (cfg_nprobes > MAX_K) begin
          hit = 1'b1;
        end else begin
          hit = 1'b1;
          for (j = 0; j < cfg_nprobes; j++) begin
            pos = h % nbits;
            if (!filter_mem[pos >> 3][pos[2:0]]) hit = 1'b0;
            h += delta;
          end
        end
        res.may_match = hit;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Result checker and receiver pacing, one process
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (fail_count < SHOW_LIMIT)
          $display("unexpected result beat: kind=%0d match=%0d",
                   out_data.done_kind, out_data.may_match);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.done_kind !== want.done_kind ||
            out_data.may_match !== want.may_match) begin
          if (fail_count < SHOW_LIMIT)
            $display("mismatch: expected kind=%0d match=%0d, got kind=%0d match=%0d",
                     want.done_kind, want.may_match,
                     out_data.done_kind, out_data.may_match);
          fail_count++;
        end
      end
    end

    // long hold-off on request from the test sequence
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (pattern_left == 0) begin
      stall_mode   = $urandom_range(0, 2);
      pattern_left = $urandom_range(20, 80);
    end else begin
      pattern_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one beat in bursts with random gaps; record the prediction on accept
  task automatic send_item(input logic [KIND_W-1:0] op, input logic [HASH_W-1:0] hv);
    in_item_t    item;
    out_item_t   exp_res;
    int unsigned gap;
    item.kind       = op;
    item.hash_value = hv;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    exp_res = filter_apply(item);
    pending_results = {pending_results, exp_res};
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FILTER_BYTES)
      cfg_fbytes = value[FB_W-1:0];
    else if (idx == CFG_NUM_PROBES)
      cfg_nprobes = value[NP_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Resize only with the engine idle
  task automatic set_filter(input int unsigned nbytes, input int unsigned nprobes);
    wait_drained();
    write_reg(CFG_FILTER_BYTES, nbytes[CFG_DATA_W-1:0]);
    write_reg(CFG_NUM_PROBES, nprobes[CFG_DATA_W-1:0]);
  endtask

  // Every operation at reset sizes, hash extremes
  task automatic test_basic_ops();
    send_item(KIND_QUERY,  32'h0000_0000);
    send_item(KIND_INSERT, 32'h0000_0000);
    send_item(KIND_QUERY,  32'h0000_0000);
    send_item(KIND_INSERT, 32'hFFFF_FFFF);
    send_item(KIND_QUERY,  32'hFFFF_FFFF);
    send_item(KIND_QUERY,  32'h8000_0000);
    send_item(KIND_RSVD,   32'h5A5A_5A5A);
    send_item(KIND_CLEAR,  32'hA5A5_A5A5);
    send_item(KIND_QUERY,  32'h0000_0000);
  endtask

  // Empty filter, oversized filter, probe counts of zero, max and beyond,
  // clear covering bytes outside the configured size, register edge cases
  task automatic test_special_cases();
    set_filter(0, 6);
    send_item(KIND_QUERY,  32'h1234_5678);
    send_item(KIND_INSERT, 32'h1234_5678);
    set_filter(8, 6);
    send_item(KIND_QUERY,  32'h1234_5678);

    set_filter(MAX_BYTES, MAX_K);
    send_item(KIND_INSERT, 32'hDEAD_BEEF);
    send_item(KIND_QUERY,  32'hDEAD_BEEF);
    set_filter(2047, MAX_K);
    send_item(KIND_QUERY,  32'hDEAD_BEEF);
    set_filter(8, 6);
    send_item(KIND_CLEAR,  32'h0000_0000);
    set_filter(MAX_BYTES, MAX_K);
    send_item(KIND_QUERY,  32'hDEAD_BEEF);

    set_filter(64, MAX_K + 1);
    send_item(KIND_QUERY,  32'hCAFE_F00D);
    send_item(KIND_INSERT, 32'hCAFE_F00D);
    set_filter(64, 255);
    send_item(KIND_QUERY,  32'h0000_0001);
    set_filter(64, 0);
    send_item(KIND_QUERY,  32'hCAFE_F00D);
    send_item(KIND_INSERT, 32'hCAFE_F00D);

    // bits above the probe count field are dropped; unused index is ignored
    wait_drained();
    write_reg(CFG_NUM_PROBES, 11'h104);
    write_reg(CFG_UNUSED, 11'h7FF);
    send_item(KIND_QUERY,  32'hCAFE_F00D);

    set_filter(1, 1);
    send_item(KIND_INSERT, 32'h0000_0007);
    send_item(KIND_QUERY,  32'h0000_0007);
    send_item(KIND_QUERY,  32'h0000_0006);
  endtask

  // Insert/query mixes over a series of sizes; queries often reuse keys
  task automatic test_random_traffic();
    int unsigned bytes_tab  [N_PHASES] = '{8, 1, 2, 32, 1024, 2047, 0, 128, 16, 256, 64, 512};
    int unsigned probes_tab [N_PHASES] = '{6, 1, 3, 4, 2, 5, 4, 30, 40, 0, 8, 12};
    int unsigned count_tab  [N_PHASES] = '{120, 100, 100, 120, 120, 100, 40, 25, 60, 40, 100, 80};
    int unsigned r;
    bit [31:0]   hv;
    for (int p = 0; p < N_PHASES; p++) begin
      set_filter(bytes_tab[p], probes_tab[p]);
      for (int n = 0; n < count_tab[p]; n++) begin
        r  = $urandom_range(0, 99);
        hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom;
        if (r < 2) begin
          send_item(KIND_CLEAR, hv);
        end else if (r < 5) begin
          send_item(KIND_RSVD, hv);
        end else if (r < 45) begin
          key_pool = {key_pool, hv};
          if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
          send_item(KIND_INSERT, hv);
        end else begin
          if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
            hv = key_pool[$urandom_range(0, key_pool.size() - 1)];
          send_item(KIND_QUERY, hv);
        end
      end
    end
  endtask

  // Receiver holds off while beats keep coming, then the sender pauses
  task automatic test_output_backpressure();
    bit [31:0] hv;
    set_filter(16, 2);
    hold_requests++;
    for (int n = 0; n < 24; n++) begin
      hv = $urandom;
      send_item(KIND_INSERT, hv);
      send_item(KIND_QUERY, hv);
    end
    wait_drained();
    set_filter(4, 1);
    for (int n = 0; n < 10; n++) send_item(KIND_QUERY, $urandom);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_special_cases();
    test_random_traffic();
    test_output_backpressure();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
